// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, word types and controller/datapath signal groups for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLS          = 80;
   localparam int ROWS          = 25;
   localparam int CELLS         = ROWS * COLS;
   localparam int COPY_CELLS    = (ROWS - 1) * COLS;
   localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;
   localparam int ADDR_W        = $clog2(CELLS);
   localparam int WALK_W        = $clog2(CELLS + 1);
   localparam int ROW_W         = $clog2(ROWS);
   localparam int COL_W         = $clog2(COLS);
   localparam int CURSOR_W      = 11;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] COLOR_RESET  = 8'd135;

   typedef enum logic [1:0] {
      OP_PUT_CHAR = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_READ     = 2'd2,
      OP_PUT_CELL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      WALK_INIT   = 2'd0,
      WALK_CLEAR  = 2'd1,
      WALK_SCROLL = 2'd2
   } walk_type;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  char_code;
      logic [7:0]  cell_color;
      logic [6:0]  cell_x;
      logic [4:0]  cell_y;
   } req_word_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_index;
      logic [15:0]         read_entry;
      logic                scrolled;
   } rsp_word_type;

   typedef struct packed {
      logic     accept;
      logic     walk_start;
      walk_type walk_mode;
      logic     walk_en;
      logic     read_capture;
      logic     load_direct;
      logic     load_held;
   } cmd_type;

   typedef struct packed {
      logic scroll_req;
      logic walk_done;
      logic wr_busy;
   } status_type;

endpackage

// ===== rtl/core/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller state machine: input acceptance, memory walks, read capture and
// loading of the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcw_pkg::op_type     req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [4:0] {
      ST_INIT = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_READ = 5'b00100,
      ST_WALK = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      req_ready    = (state_ff == ST_IDLE);
      cmd          = '0;
      cmd.accept   = req_valid && req_ready;
      cmd.walk_en  = (state_ff == ST_INIT) || (state_ff == ST_WALK);
      cmd.walk_mode = WALK_INIT;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_INIT: begin
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.accept) begin
               unique case (req_opcode) inside
                  OP_PUT_CHAR, OP_PUT_CELL: begin
                     if (status.scroll_req) begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_mode  = WALK_SCROLL;
                        state_in       = ST_WALK;
                     end else if (out_free) begin
                        cmd.load_direct = 1'b1;
                        rsp_valid_in    = 1'b1;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.walk_start = 1'b1;
                     cmd.walk_mode  = WALK_CLEAR;
                     state_in       = ST_WALK;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_RESP;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.load_held = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/tcw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, colour register, walk counter for clear and scroll,
// and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::cmd_type      cmd,
   output tcw_pkg::status_type   status,
   input  tcw_pkg::req_word_type req_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data,
   output tcw_pkg::rsp_word_type rsp_word
);
   import tcw_pkg::*;

   logic [15:0]       mem [CELLS];

   logic [7:0]        color_ff, color_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [WALK_W-1:0] walk_ff, walk_in;
   walk_type          mode_ff, mode_in;
   logic              wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic              wr_copy_ff;
   logic              wr_init_ff;
   logic [15:0]       rd_data_ff;
   logic              rd_range_ff;
   logic [15:0]       res_read_ff;
   logic              res_scroll_ff;
   rsp_word_type      rsp_ff;

   logic              in_range;
   logic [ADDR_W-1:0] pos_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              is_newline;
   logic              last_col;
   logic              last_row;
   logic              put_char;
   logic              put_cell;
   logic              row_adv;
   logic              walk_active;
   logic [15:0]       blank;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;

   assign csr_ready = 1'b1;
   assign color_in  = csr_valid ? csr_data : color_ff;

   always_comb begin
      in_range   = (32'(req_word.cell_x) < COLS) && (32'(req_word.cell_y) < ROWS);
      pos_addr   = ADDR_W'(32'(req_word.cell_y) * COLS + 32'(req_word.cell_x));
      is_newline = (req_word.char_code == CHAR_NEWLINE);
      last_col   = (col_ff == COL_W'(COLS - 1));
      last_row   = (row_ff == ROW_W'(ROWS - 1));
      put_char   = (req_word.opcode == OP_PUT_CHAR);
      put_cell   = (req_word.opcode == OP_PUT_CELL);
      row_adv    = is_newline || last_col;
      status.scroll_req = put_char && row_adv && last_row;

      // cursor advance
      row_in    = row_ff;
      col_in    = col_ff;
      cursor_in = cursor_ff;
      if (cmd.accept && put_char) begin
         if (row_adv) begin
            col_in = '0;
            if (last_row) begin
               cursor_in = ADDR_W'(LAST_ROW_BASE);
            end else begin
               row_in = row_ff + 1'b1;
               if (is_newline) begin
                  cursor_in = cursor_ff - ADDR_W'(col_ff) + ADDR_W'(COLS);
               end else begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
         end else begin
            col_in    = col_ff + 1'b1;
            cursor_in = cursor_ff + 1'b1;
         end
      end

      // memory walk, each write follows its read in the next cycle
      status.walk_done = (walk_ff == WALK_W'(CELLS));
      status.wr_busy   = wr_valid_ff;
      walk_active      = cmd.walk_en && !status.walk_done;
      if (cmd.walk_start) begin
         walk_in = '0;
      end else if (walk_active) begin
         walk_in = walk_ff + 1'b1;
      end else begin
         walk_in = walk_ff;
      end
      mode_in     = cmd.walk_start ? cmd.walk_mode : mode_ff;
      wr_valid_in = walk_active;

      if (cmd.walk_en) begin
         rd_addr = ADDR_W'(32'(walk_ff) + COLS);
      end else begin
         rd_addr = pos_addr;
      end

      blank = wr_init_ff ? {COLOR_RESET, CHAR_SPACE} : {color_ff, CHAR_SPACE};

      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = wr_copy_ff ? rd_data_ff : blank;
      if (wr_valid_ff) begin
         mem_we = 1'b1;
      end else if (cmd.accept && put_char && !is_newline) begin
         mem_we    = 1'b1;
         mem_waddr = cursor_ff;
         mem_wdata = {color_ff, req_word.char_code};
      end else if (cmd.accept && put_cell && in_range) begin
         mem_we    = 1'b1;
         mem_waddr = pos_addr;
         mem_wdata = {req_word.cell_color, req_word.char_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff    <= COLOR_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         cursor_ff   <= '0;
         walk_ff     <= '0;
         mode_ff     <= WALK_INIT;
         wr_valid_ff <= 1'b0;
      end else begin
         color_ff    <= color_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         cursor_ff   <= cursor_in;
         walk_ff     <= walk_in;
         mode_ff     <= mode_in;
         wr_valid_ff <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= walk_ff[ADDR_W-1:0];
      wr_copy_ff <= (mode_ff == WALK_SCROLL) && (walk_ff < WALK_W'(COPY_CELLS));
      wr_init_ff <= (mode_ff == WALK_INIT);
      if (cmd.accept) begin
         rd_range_ff   <= in_range;
         res_read_ff   <= '0;
         res_scroll_ff <= status.scroll_req;
      end else if (cmd.read_capture) begin
         res_read_ff <= rd_range_ff ? rd_data_ff : '0;
      end
      if (cmd.load_direct) begin
         rsp_ff.cursor_index <= CURSOR_W'(cursor_in);
         rsp_ff.read_entry   <= '0;
         rsp_ff.scrolled     <= 1'b0;
      end else if (cmd.load_held) begin
         rsp_ff.cursor_index <= CURSOR_W'(cursor_ff);
         rsp_ff.read_entry   <= res_read_ff;
         rsp_ff.scrolled     <= res_scroll_ff;
      end
   end

   // screen memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== rtl/core/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text screen of ROWS x COLS character cells with a cursor, scrolling and
// clear, driven by one command word per request.
//
// Request words (req_) carry an opcode: put character at cursor, clear
// screen, read cell, put cell at position. Each request gives one response
// word (rsp_) with the cursor index, read data and a scroll flag.
// csr_ takes writes of the text colour at any time; csr_ready is always high.
// Put character and put cell: one word per cycle while the response register
// is free and no scroll is due; the response is registered on acceptance or
// waits in ST_RESP. Read cell: the registered read port of the screen memory
// feeds the cell through ST_READ and ST_RESP to the response register.
// Clear and scroll: the screen memory is walked one cell a cycle; req_ready
// is low. Reset: a clearing pass fills the screen with spaces in the reset
// colour; req_ready stays low until it ends.
// Receiver stall: the response register holds its word; one further request
// is accepted and executed, then its response waits until the register frees.
// ----------------------------------------------------------------------------
module text_console_writer_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcw_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tcw_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_word.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   tcw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_word  (rsp_word)
   );

   a_no_accept_during_walk_write: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !status.wr_busy)
      else $error("word accepted while a walk write is pending");

   a_scroll_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.scroll_req) |=> !req_ready)
      else $error("input not stalled for scroll");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_en && status.walk_done) |=> !cmd.walk_en)
      else $error("walk continued past its end");

   a_scroll_no_read_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.scrolled) |-> (rsp_word.read_entry == '0))
      else $error("scroll response carries read data");

endmodule

// ===== dv/text_console_writer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the text console writer. A driver feeds request
// words from a queue and a monitor checks every response word against a
// model of the screen memory and cursor. Covers edge values, out-of-range
// cells, newline and row wrap with scrolling, clear, colour changes between
// phases and several idling/stall patterns with one long receiver hold-off.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
   import tcw_pkg::*;

   localparam int HOLD_LEN = 300;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data  = '0;

   req_word_type req_pending[$];
   rsp_word_type rsp_predicted[$];

   logic        req_taken = 1'b0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   logic        hold_arm  = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          mismatch_count = 0;

   // model state
   logic [15:0] screen_mem [CELLS];
   int          cur_row;
   int          cur_col;
   logic [7:0]  text_color;

   text_console_writer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) screen_mem[i] = {text_color, CHAR_SPACE};
   endfunction

   function automatic logic advance_row();
      if (cur_row + 1 >= ROWS) begin
         for (int i = 0; i < COPY_CELLS; i++) screen_mem[i] = screen_mem[i + COLS];
         for (int i = LAST_ROW_BASE; i < CELLS; i++) screen_mem[i] = {text_color, CHAR_SPACE};
         cur_row = ROWS - 1;
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   function automatic rsp_word_type console_step(req_word_type w);
      rsp_word_type r;
      logic         hit;
      int           cell_idx;
      r   = '0;
      hit = (int'(w.cell_x) < COLS) && (int'(w.cell_y) < ROWS);
      cell_idx = int'(w.cell_y) * COLS + int'(w.cell_x);
      case (w.opcode)
         OP_PUT_CHAR: begin
            if (w.char_code == CHAR_NEWLINE) begin
               cur_col    = 0;
               r.scrolled = advance_row();
            end else begin
               screen_mem[cur_row * COLS + cur_col] = {text_color, w.char_code};
               cur_col++;
               if (cur_col >= COLS) begin
                  cur_col    = 0;
                  r.scrolled = advance_row();
               end
            end
         end
         OP_CLEAR: blank_screen();
         OP_READ: begin
            if (hit) r.read_entry = screen_mem[cell_idx];
         end
         default: begin
            if (hit) screen_mem[cell_idx] = {w.cell_color, w.char_code};
         end
      endcase
      r.cursor_index = CURSOR_W'(cur_row * COLS + cur_col);
      return r;
   endfunction

   task automatic check_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   // monitor and model update
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         req_taken  <= 1'b0;
         cur_row     = 0;
         cur_col     = 0;
         text_color  = COLOR_RESET;
         blank_screen();
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) text_color = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (rsp_predicted.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %h",
                        $time, rsp_word);
               mismatch_count++;
            end else begin
               exp_w = rsp_predicted.pop_front();
               check_field("cursor_index", exp_w.cursor_index, rsp_word.cursor_index);
               check_field("read_entry", exp_w.read_entry, rsp_word.read_entry);
               check_field("scrolled", exp_w.scrolled, rsp_word.scrolled);
            end
         end
         if (req_valid && req_ready) rsp_predicted.push_back(console_step(req_word));
      end
   end

   // request driver
   always @(negedge clock) begin
      logic         nxt_valid;
      req_word_type nxt_word;
      nxt_valid = req_valid;
      nxt_word  = req_word;
      if (req_taken) nxt_valid = 1'b0;
      if (!nxt_valid && req_pending.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
         nxt_valid = 1'b1;
         nxt_word  = req_pending.pop_front();
      end
      req_valid <= nxt_valid;
      req_word  <= nxt_word;
   end

   // response ready, with long hold-off on request
   always @(negedge clock) begin
      if (hold_arm != hold_seen) begin
         hold_seen <= hold_arm;
         hold_left <= HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic req_word_type mk_word(op_type op, int ch, int color, int x, int y);
      req_word_type w;
      w.opcode     = op;
      w.char_code  = 8'(ch);
      w.cell_color = 8'(color);
      w.cell_x     = 7'(x);
      w.cell_y     = 5'(y);
      return w;
   endfunction

   function automatic int pick_col();
      if ($urandom_range(99) < 85) return $urandom_range(COLS - 1);
      return $urandom_range(127);
   endfunction

   function automatic int pick_row();
      int r;
      r = $urandom_range(99);
      if (r < 30) return ROWS - 1;
      if (r < 85) return $urandom_range(ROWS - 1);
      return $urandom_range(31);
   endfunction

   function automatic req_word_type rand_word(op_type op);
      return mk_word(op, $urandom_range(255), $urandom_range(255), pick_col(), pick_row());
   endfunction

   task automatic add_random(input int n);
      int count;
      int len;
      int ch;
      int r;
      count = 0;
      while (count < n) begin
         if ($urandom_range(99) < 55) begin
            // a text line, mostly short, now and then long enough to wrap
            len = ($urandom_range(9) == 0) ? $urandom_range(75, 90) : $urandom_range(15);
            for (int i = 0; i < len; i++) begin
               ch = $urandom_range(255);
               if (ch == CHAR_NEWLINE) ch = CHAR_SPACE;
               req_pending.push_back(mk_word(OP_PUT_CHAR, ch, $urandom_range(255),
                                             $urandom_range(127), $urandom_range(31)));
            end
            count += len;
            if ($urandom_range(9) != 0) begin
               req_pending.push_back(mk_word(OP_PUT_CHAR, CHAR_NEWLINE, $urandom_range(255),
                                             $urandom_range(127), $urandom_range(31)));
               count++;
            end
         end else begin
            r = $urandom_range(99);
            if (r < 45) req_pending.push_back(rand_word(OP_READ));
            else if (r < 85) req_pending.push_back(rand_word(OP_PUT_CELL));
            else if (r < 90) req_pending.push_back(rand_word(OP_CLEAR));
            else req_pending.push_back(rand_word(OP_PUT_CHAR));
            count++;
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (req_pending.size() != 0 || req_valid || rsp_predicted.size() != 0);
   endtask

   task automatic write_color(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [7:0] color, input int send_pct, input int recv_pct,
                            input int n, input logic hold);
      wait_idle();
      write_color(color);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (hold) hold_arm = ~hold_arm;
      add_random(n);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset contents, edge values, out-of-range cells, clear
      req_pending.push_back(mk_word(OP_READ, 0, 0, 0, 0));
      req_pending.push_back(mk_word(OP_READ, 0, 0, COLS - 1, ROWS - 1));
      req_pending.push_back(mk_word(OP_PUT_CHAR, 8'h00, 8'hFF, 127, 31));
      req_pending.push_back(mk_word(OP_PUT_CHAR, 8'hFF, 8'h00, 0, 0));
      req_pending.push_back(mk_word(OP_PUT_CELL, 8'hFF, 8'hFF, 0, 0));
      req_pending.push_back(mk_word(OP_PUT_CELL, 8'h00, 8'h00, COLS - 1, ROWS - 1));
      req_pending.push_back(mk_word(OP_PUT_CELL, 8'h55, 8'hAA, COLS, 0));
      req_pending.push_back(mk_word(OP_PUT_CELL, 8'hAA, 8'h55, 0, ROWS));
      req_pending.push_back(mk_word(OP_PUT_CELL, 8'hFF, 8'hFF, 127, 31));
      req_pending.push_back(mk_word(OP_READ, 0, 0, 0, 0));
      req_pending.push_back(mk_word(OP_READ, 0, 0, 1, 0));
      req_pending.push_back(mk_word(OP_READ, 0, 0, COLS - 1, ROWS - 1));
      req_pending.push_back(mk_word(OP_READ, 0, 0, COLS, 0));
      req_pending.push_back(mk_word(OP_READ, 0, 0, 0, ROWS));
      req_pending.push_back(mk_word(OP_READ, 8'hFF, 8'hFF, 127, 31));
      req_pending.push_back(mk_word(OP_CLEAR, 0, 0, 0, 0));
      req_pending.push_back(mk_word(OP_READ, 0, 0, 0, 0));

      // new colour, then newlines down to the last row and one more to scroll
      wait_idle();
      write_color(8'hFF);
      req_pending.push_back(mk_word(OP_CLEAR, 8'hFF, 8'hFF, 127, 31));
      for (int i = 0; i < ROWS; i++)
         req_pending.push_back(mk_word(OP_PUT_CHAR, CHAR_NEWLINE, 0, 0, 0));
      req_pending.push_back(mk_word(OP_READ, 0, 0, 0, ROWS - 1));
      req_pending.push_back(mk_word(OP_READ, 0, 0, COLS - 1, 0));

      run_phase(8'h00, 0, 0, 360, 1'b1);
      run_phase(8'($urandom_range(255)), 85, 0, 360, 1'b0);
      run_phase(8'hFF, 0, 85, 360, 1'b0);
      run_phase(8'($urandom_range(255)), 27, 27, 360, 1'b0);

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && rsp_predicted.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
